>>> hw/rtl/cpt_pkg.sv
// Shared types and constants of the color palette table engine.
package cpt_pkg;

    // Operation codes carried in the operation field of an input transaction.
    localparam logic [2:0] OP_READ    = 3'd0;
    localparam logic [2:0] OP_WRITE   = 3'd1;
    localparam logic [2:0] OP_FIND    = 3'd2;
    localparam logic [2:0] OP_ROT_FWD = 3'd3;
    localparam logic [2:0] OP_ROT_BWD = 3'd4;
    localparam logic [2:0] OP_GRAY    = 3'd5;

    // Q0.16 luma weights for 0.299, 0.587 and 0.114; they sum to one.
    localparam logic [15:0] W_RED   = 16'd19595;
    localparam logic [15:0] W_GREEN = 16'd38470;
    localparam logic [15:0] W_BLUE  = 16'd7471;

    localparam logic [23:0] COLOR_BLACK = 24'h000000;
    localparam logic [23:0] COLOR_WHITE = 24'hFFFFFF;

    typedef struct packed {
        logic [2:0]  operation;
        logic [7:0]  entry_index;
        logic [7:0]  red_in;
        logic [7:0]  green_in;
        logic [7:0]  blue_in;
        logic [15:0] rotate_amount;
    } cpt_item_t;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic [7:0] match_index;
        logic       match_found;
        logic       index_error;
    } cpt_result_t;

    // One slot of the read pipeline: whether it holds data and which entry it is.
    typedef struct packed {
        logic       valid;
        logic [8:0] index;
    } cpt_pipe_t;

endpackage

>>> hw/rtl/cpt_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module cpt_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> hw/rtl/cpt_mod.sv
// Bit-serial remainder unit: one restoring step per cycle over a 16-bit dividend.
module cpt_mod (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [15:0] dividend,
    input  logic [8:0]  divisor,
    output logic        done,
    output logic [8:0]  remainder
);

    localparam int STEPS  = 16;
    localparam int STEP_W = $clog2(STEPS);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(STEPS - 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [15:0]       shift_reg, shift_next;
    logic [8:0]        div_reg, div_next;
    logic [8:0]        rem_reg, rem_next;
    logic [9:0]        trial;
    logic [9:0]        diff;

    assign trial = {rem_reg, shift_reg[15]};
    assign diff  = trial - {1'b0, div_reg};

    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        step_next  = step_reg;
        shift_next = shift_reg;
        div_next   = div_reg;
        rem_next   = rem_reg;
        if (start)
        begin
            busy_next  = 1'b1;
            step_next  = '0;
            shift_next = dividend;
            div_next   = divisor;
            rem_next   = '0;
        end
        else if (busy_reg)
        begin
            // The partial remainder stays below the divisor, so it fits in 9 bits.
            rem_next   = (trial >= {1'b0, div_reg}) ? diff[8:0] : trial[8:0];
            shift_next = {shift_reg[14:0], 1'b0};
            step_next  = step_reg + 1'b1;
            if (step_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg  <= step_next;
        shift_reg <= shift_next;
        div_reg   <= div_next;
        rem_reg   <= rem_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

>>> hw/rtl/cpt_gray.sv
// Two-stage luma pipeline: weighted products, then their sum truncated to 8 bits.
module cpt_gray (
    input  logic                clk,
    input  logic                rst_n,
    input  cpt_pkg::cpt_pipe_t  src,
    input  logic [23:0]         color,
    output cpt_pkg::cpt_pipe_t  dst,
    output logic [7:0]          luma
);

    cpt_pkg::cpt_pipe_t prod_pipe_reg;
    cpt_pkg::cpt_pipe_t sum_pipe_reg;
    logic [23:0]        prod_r_reg, prod_g_reg, prod_b_reg;
    logic [23:0]        prod_r_next, prod_g_next, prod_b_next;
    logic [23:0]        sum;
    logic [7:0]         luma_reg;

    assign prod_r_next = 24'(cpt_pkg::W_RED)   * 24'(color[23:16]);
    assign prod_g_next = 24'(cpt_pkg::W_GREEN) * 24'(color[15:8]);
    assign prod_b_next = 24'(cpt_pkg::W_BLUE)  * 24'(color[7:0]);

    // The weights sum to 65536, so the total never exceeds 255 * 65536.
    assign sum = prod_r_reg + prod_g_reg + prod_b_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_pipe_reg <= '0;
            sum_pipe_reg  <= '0;
        end
        else
        begin
            prod_pipe_reg <= src;
            sum_pipe_reg  <= prod_pipe_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_r_reg <= prod_r_next;
        prod_g_reg <= prod_g_next;
        prod_b_reg <= prod_b_next;
        luma_reg   <= sum[23:16];
    end

    assign dst  = sum_pipe_reg;
    assign luma = luma_reg;

endmodule

>>> hw/rtl/color_palette_table_engine.sv
// Top level of the color palette table engine: sequencer, palette RAM and datapath.
//
// Usage. Input transactions arrive on item_valid/item_stall with the payload in item;
// one result transaction per input leaves on result_valid/result_stall with the payload
// in result. A transaction moves at a clock edge where valid is high and stall is low.
// Write the color count register (cfg_write/cfg_data) only while idle; left unchecked.
//
// Sequencing. The palette lives in a synchronous RAM with a registered read, and every
// input is handled on its own. An out-of-range read or write and an unused code go
// straight to the result register; a write passes the dispatch state first, and a read
// also waits for the RAM data. A find, which stops at the first match, and a gray
// conversion walk the one RAM read port one entry a cycle. A rotation waits on the
// bit-serial remainder unit (16 steps). Whenever the rotation base is not below the
// count, an in-range read or write, a find and a rotate first reduce it in that unit.
//
// Reset. After rst_n is released the block clears the first min(256, PALETTE_DEPTH)
// palette entries to black with entry one white; item_stall is high meanwhile.
// Configuration writes are taken during that pass.
//
// Stalls. The result register holds a finished result while result_stall is high; the
// next input transaction is still accepted and its result waits until the register frees.
module color_palette_table_engine #(
    parameter int PALETTE_DEPTH = 256
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [8:0]           cfg_data,
    input  logic                 item_valid,
    output logic                 item_stall,
    input  cpt_pkg::cpt_item_t   item,
    output logic                 result_valid,
    input  logic                 result_stall,
    output cpt_pkg::cpt_result_t result
);

    localparam int ADDR_W     = $clog2(PALETTE_DEPTH);
    localparam int MAX_IN_USE = (PALETTE_DEPTH < 256) ? PALETTE_DEPTH : 256;
    localparam logic [8:0] MAX_COUNT  = 9'(MAX_IN_USE);
    localparam logic [8:0] LAST_CLEAR = 9'(MAX_IN_USE - 1);

    typedef enum logic [8:0] {
        S_CLEAR = 9'b000000001,
        S_IDLE  = 9'b000000010,
        S_BMOD  = 9'b000000100,
        S_DISP  = 9'b000001000,
        S_RDATA = 9'b000010000,
        S_FIND  = 9'b000100000,
        S_KMOD  = 9'b001000000,
        S_GRAY  = 9'b010000000,
        S_RESP  = 9'b100000000
    } state_t;

    state_t               state_reg, state_next;
    logic [8:0]           count_reg, count_next;
    logic [7:0]           base_reg, base_next;
    logic [8:0]           bm_reg, bm_next;
    logic [8:0]           clear_reg, clear_next;
    logic [8:0]           iss_cnt_reg, iss_cnt_next;
    logic [8:0]           iss_slot_reg, iss_slot_next;
    cpt_pkg::cpt_pipe_t   pipe_reg, pipe_next;
    cpt_pkg::cpt_item_t   item_reg, item_next;
    cpt_pkg::cpt_result_t res_reg, res_next;
    cpt_pkg::cpt_result_t out_reg, out_next;
    logic                 out_valid_reg, out_valid_next;

    // Datapath signals.
    logic [8:0]         cnt;
    logic               base_ok;
    logic               idx_bad;
    logic [8:0]         slot_sum;
    logic [8:0]         slot_rw;
    logic [9:0]         fwd_sum;
    logic [9:0]         bwd_sum;
    logic [9:0]         rot_sum;
    logic [9:0]         rot_wrapped;
    logic [23:0]        item_color;
    logic               issue;
    logic               can_load;

    // RAM, remainder unit and luma pipeline hookup.
    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr;
    logic [23:0]        ram_wdata;
    logic [ADDR_W-1:0]  ram_raddr;
    logic [23:0]        ram_rdata;
    logic               mod_start;
    logic [15:0]        mod_dividend;
    logic               mod_done;
    logic [8:0]         mod_rem;
    cpt_pkg::cpt_pipe_t gray_src;
    cpt_pkg::cpt_pipe_t gray_dst;
    logic [7:0]         gray_luma;

    cpt_ram #(
        .WIDTH (24),
        .DEPTH (PALETTE_DEPTH)
    ) u_palette (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    cpt_mod u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (mod_start),
        .dividend  (mod_dividend),
        .divisor   (cnt),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    cpt_gray u_gray (
        .clk   (clk),
        .rst_n (rst_n),
        .src   (gray_src),
        .color (ram_rdata),
        .dst   (gray_dst),
        .luma  (gray_luma)
    );

    // The count in use is the register clamped to one and to the largest usable depth.
    always_comb
    begin
        priority if (count_reg == '0)
        begin
            cnt = 9'd1;
        end
        else if (count_reg > MAX_COUNT)
        begin
            cnt = MAX_COUNT;
        end
        else
        begin
            cnt = count_reg;
        end
    end

    assign base_ok    = {1'b0, base_reg} < cnt;
    assign idx_bad    = {1'b0, item.entry_index} >= cnt;
    assign item_color = {item_reg.red_in, item_reg.green_in, item_reg.blue_in};

    // Logical index plus the reduced base; both are below the count, so one
    // conditional subtract wraps the physical slot.
    assign slot_sum = {1'b0, item_reg.entry_index} + bm_reg;
    assign slot_rw  = (slot_sum >= cnt) ? slot_sum - cnt : slot_sum;

    // A forward rotation lowers the base, a backward one raises it; both sums stay
    // below twice the count.
    assign fwd_sum     = {1'b0, bm_reg} + {1'b0, cnt} - {1'b0, mod_rem};
    assign bwd_sum     = {1'b0, bm_reg} + {1'b0, mod_rem};
    assign rot_sum     = (item_reg.operation == cpt_pkg::OP_ROT_FWD) ? fwd_sum : bwd_sum;
    assign rot_wrapped = (rot_sum >= {1'b0, cnt}) ? rot_sum - {1'b0, cnt} : rot_sum;

    assign issue    = iss_cnt_reg < cnt;
    assign can_load = !out_valid_reg || !result_stall;

    assign gray_src.valid = pipe_reg.valid && (state_reg == S_GRAY);
    assign gray_src.index = pipe_reg.index;

    assign mod_dividend = (state_reg == S_IDLE) ? {8'd0, base_reg} : item_reg.rotate_amount;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = cfg_write ? cfg_data : count_reg;
        base_next      = base_reg;
        bm_next        = bm_reg;
        clear_next     = clear_reg;
        iss_cnt_next   = iss_cnt_reg;
        iss_slot_next  = iss_slot_reg;
        pipe_next      = '0;
        item_next      = item_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && result_stall;
        ram_we         = 1'b0;
        ram_waddr      = '0;
        ram_wdata      = cpt_pkg::COLOR_BLACK;
        ram_raddr      = '0;
        mod_start      = 1'b0;

        unique case (state_reg)
            S_CLEAR:
            begin
                ram_we     = 1'b1;
                ram_waddr  = ADDR_W'(clear_reg);
                ram_wdata  = (clear_reg == 9'd1) ? cpt_pkg::COLOR_WHITE : cpt_pkg::COLOR_BLACK;
                clear_next = clear_reg + 1'b1;
                if (clear_reg == LAST_CLEAR)
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (item_valid)
                begin
                    item_next    = item;
                    res_next     = '0;
                    iss_cnt_next = '0;
                    unique case (item.operation)
                        cpt_pkg::OP_READ, cpt_pkg::OP_WRITE,
                        cpt_pkg::OP_FIND, cpt_pkg::OP_ROT_FWD, cpt_pkg::OP_ROT_BWD:
                        begin
                            priority if ((item.operation == cpt_pkg::OP_READ ||
                                          item.operation == cpt_pkg::OP_WRITE) && idx_bad)
                            begin
                                res_next.index_error = 1'b1;
                                state_next           = S_RESP;
                            end
                            else if (base_ok)
                            begin
                                bm_next    = {1'b0, base_reg};
                                state_next = S_DISP;
                            end
                            else
                            begin
                                // The count shrank to the base or below: reduce it first.
                                mod_start  = 1'b1;
                                state_next = S_BMOD;
                            end
                        end
                        cpt_pkg::OP_GRAY:
                        begin
                            state_next = S_GRAY;
                        end
                        default:
                        begin
                            state_next = S_RESP;
                        end
                    endcase
                end
            end

            S_BMOD:
            begin
                if (mod_done)
                begin
                    bm_next    = mod_rem;
                    state_next = S_DISP;
                end
            end

            S_DISP:
            begin
                unique case (item_reg.operation)
                    cpt_pkg::OP_READ:
                    begin
                        ram_raddr  = ADDR_W'(slot_rw);
                        state_next = S_RDATA;
                    end
                    cpt_pkg::OP_WRITE:
                    begin
                        ram_we     = 1'b1;
                        ram_waddr  = ADDR_W'(slot_rw);
                        ram_wdata  = item_color;
                        state_next = S_RESP;
                    end
                    cpt_pkg::OP_FIND:
                    begin
                        iss_slot_next = bm_reg;
                        state_next    = S_FIND;
                    end
                    default:
                    begin
                        // Both rotations reduce the amount modulo the count.
                        mod_start  = 1'b1;
                        state_next = S_KMOD;
                    end
                endcase
            end

            S_RDATA:
            begin
                res_next.red_out   = ram_rdata[23:16];
                res_next.green_out = ram_rdata[15:8];
                res_next.blue_out  = ram_rdata[7:0];
                state_next         = S_RESP;
            end

            S_FIND:
            begin
                // Reads go out one logical index a cycle; each compare is made on the registered
                // RAM output.
                ram_raddr = ADDR_W'(iss_slot_reg);
                if (issue)
                begin
                    pipe_next.valid = 1'b1;
                    pipe_next.index = iss_cnt_reg;
                    iss_cnt_next    = iss_cnt_reg + 1'b1;
                    iss_slot_next   = (iss_slot_reg + 1'b1 == cnt) ? '0 : iss_slot_reg + 1'b1;
                end
                if (pipe_reg.valid)
                begin
                    if (ram_rdata == item_color)
                    begin
                        res_next.match_index = pipe_reg.index[7:0];
                        res_next.match_found = 1'b1;
                        state_next           = S_RESP;
                    end
                    else if (pipe_reg.index == cnt - 1'b1)
                    begin
                        state_next = S_RESP;
                    end
                end
            end

            S_KMOD:
            begin
                if (mod_done)
                begin
                    base_next  = rot_wrapped[7:0];
                    state_next = S_RESP;
                end
            end

            S_GRAY:
            begin
                // Reads run ahead of the luma pipeline, so a write back never meets a
                // pending read of the same entry.
                ram_raddr = ADDR_W'(iss_cnt_reg);
                if (issue)
                begin
                    pipe_next.valid = 1'b1;
                    pipe_next.index = iss_cnt_reg;
                    iss_cnt_next    = iss_cnt_reg + 1'b1;
                end
                if (gray_dst.valid)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = ADDR_W'(gray_dst.index);
                    ram_wdata = {gray_luma, gray_luma, gray_luma};
                    if (gray_dst.index == cnt - 1'b1)
                    begin
                        state_next = S_RESP;
                    end
                end
            end

            S_RESP:
            begin
                if (can_load)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            count_reg     <= 9'd2;
            base_reg      <= '0;
            clear_reg     <= '0;
            pipe_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            base_reg      <= base_next;
            clear_reg     <= clear_next;
            pipe_reg      <= pipe_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bm_reg       <= bm_next;
        iss_cnt_reg  <= iss_cnt_next;
        iss_slot_reg <= iss_slot_next;
        item_reg     <= item_next;
        res_reg      <= res_next;
        out_reg      <= out_next;
    end

    assign item_stall   = (state_reg != S_IDLE);
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule
